// ----- hw/rtl/dhp_pkg.sv -----
// dhp_pkg: field widths, command and status codes and the packed transfer
// types of the discrete hazard block. Depends on nothing.
`default_nettype none

package dhp_pkg;

  // Fixed field widths of the two channels.
  localparam int CMD_W    = 2;
  localparam int WEIGHT_W = 16;
  localparam int DAY_W    = 8;
  localparam int PROB_W   = 17;
  localparam int LEN_W    = 7;
  localparam int STAT_W   = 2;

  // Default sizing of the top level.
  localparam int MAX_DAYS_DEF    = 64;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [WEIGHT_W-1:0] weight;
    logic [DAY_W-1:0]    day_index;
  } in_item_t;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic [PROB_W-1:0] hazard;
    logic [LEN_W-1:0]  length;
    logic [STAT_W-1:0] status;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/discrete_hazard_from_pmf.sv -----
// discrete_hazard_from_pmf: weight store with prefix sums and a shared
// restoring divider that answers probability and hazard queries.
// Depends on dhp_pkg.
`default_nettype none

// Channel    Ports                        Handshake
// command    start, busy, in_data         transfer when start high, busy low
// result     out_valid, out_data          one-cycle strobe, never held off
//
// Clear, append and the unused command code never raise busy. A query for a
// day beyond the loaded length strobes its result in the next cycle without
// raising busy. A query for a loaded day holds busy high through the
// registered store read, then FRAC_BITS+1 steps of the shared divider for the
// probability and as many again for the hazard; the result strobes in the
// cycle in which busy falls. Reset (rst_n low, synchronous) empties the store;
// the receiver cannot stall, so a result is shown for exactly one cycle.

module discrete_hazard_from_pmf #(
  parameter int MAX_DAYS    = dhp_pkg::MAX_DAYS_DEF,
  parameter int WEIGHT_BITS = dhp_pkg::WEIGHT_BITS_DEF,
  parameter int FRAC_BITS   = dhp_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dhp_pkg::in_item_t   in_data,
  output logic                out_valid,
  output dhp_pkg::out_item_t  out_data
);

  import dhp_pkg::*;

  // Day count holds 0..MAX_DAYS; the total can never exceed
  // MAX_DAYS * (2^WEIGHT_BITS - 1), which fits in TW bits.
  localparam int CW  = $clog2(MAX_DAYS + 1);
  localparam int AW  = $clog2(MAX_DAYS);
  localparam int TW  = WEIGHT_BITS + CW;
  localparam int MW  = WEIGHT_BITS + TW;
  localparam int QW  = FRAC_BITS + 1;
  localparam int STW = $clog2(QW);
  localparam int DXW = (CW > DAY_W) ? CW : DAY_W;
  localparam int WXW = (WEIGHT_BITS > WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int QXW = (QW > PROB_W) ? QW : PROB_W;
  localparam int LXW = (CW > LEN_W) ? CW : LEN_W;

  localparam logic [QW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIVP = 4'b0100,
    ST_DIVH = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [TW-1:0]    total_r, total_nxt;
  logic             ovf_r, ovf_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [TW-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    quot_r, quot_nxt;
  logic [STW-1:0]   step_r, step_nxt;
  logic [QW-1:0]    prob_r, prob_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Each store entry packs the day's weight above its prefix sum.
  logic [MW-1:0]    mem [MAX_DAYS];
  logic [MW-1:0]    rd_data_r;

  logic             in_xfer;
  logic             full;
  logic             mem_we;
  logic [WXW-1:0]   w_ext;
  logic [WEIGHT_BITS-1:0] w_in;
  logic [DXW-1:0]   day_ext;
  logic [DXW-1:0]   cnt_dext;
  logic             in_range;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic [TW-1:0]    rd_prefix;
  logic [TW-1:0]    mass_left;
  logic [TW-1:0]    den;
  logic [TW:0]      trial;
  logic [TW:0]      diff;
  logic             ge;
  logic [TW-1:0]    rem_step;
  logic [QW-1:0]    quot_step;
  logic             last_step;
  logic [QW-1:0]    prob_src;
  logic [QW-1:0]    haz_src;
  logic [QXW-1:0]   prob_x;
  logic [QXW-1:0]   haz_x;
  logic [LXW-1:0]   len_x;
  logic [STAT_W-1:0] status_now;

  assign busy      = (state_r != ST_IDLE);
  assign in_xfer   = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Input decoding: the weight keeps its low WEIGHT_BITS bits.
  assign w_ext    = WXW'(in_data.weight);
  assign w_in     = w_ext[WEIGHT_BITS-1:0];
  assign day_ext  = DXW'(in_data.day_index);
  assign cnt_dext = DXW'(count_r);
  assign in_range = (day_ext < cnt_dext);
  assign full     = (count_r == CW'(MAX_DAYS));
  assign mem_we   = in_xfer && (in_data.command == CMD_APPEND) && !full;

  // Remaining mass from the queried day onward.
  assign rd_w      = rd_data_r[MW-1:TW];
  assign rd_prefix = rd_data_r[TW-1:0];
  assign mass_left = total_r - rd_prefix;

  // Shared restoring divider step. The first step compares the numerator
  // itself and yields the integer bit; every later step shifts the partial
  // remainder. The quotient shifts in one bit per step, so after FRAC_BITS+1
  // steps no stale bit is left.
  assign den       = (state_r == ST_DIVH) ? mass_left : total_r;
  assign trial     = (step_r == '0) ? {1'b0, TW'(rd_w)} : {rem_r, 1'b0};
  assign diff      = trial - {1'b0, den};
  assign ge        = (trial >= {1'b0, den});
  assign rem_step  = ge ? diff[TW-1:0] : trial[TW-1:0];
  assign quot_step = {quot_r[QW-2:0], ge};
  assign last_step = (step_r == STW'(FRAC_BITS));

  // Result selection. A zero remaining mass gives a hazard of 1.0; a day past
  // the loaded length is handled in the idle state with the same constant.
  assign prob_src = (state_r == ST_DIVH) ? prob_r : '0;
  assign haz_src  = ((state_r == ST_DIVH) && (mass_left != '0)) ? quot_step : ONE_Q;
  assign prob_x   = QXW'(prob_src);
  assign haz_x    = QXW'(haz_src);
  assign len_x    = LXW'(count_r);

  // An empty total outranks the overflow report.
  always_comb begin
    if (total_r == '0) begin
      status_now = STAT_EMPTY;
    end else if (ovf_r) begin
      status_now = STAT_OVERFLOW;
    end else begin
      status_now = STAT_OK;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    addr_nxt      = addr_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    step_nxt      = step_r;
    prob_nxt      = prob_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_data.command)
            CMD_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            CMD_APPEND: begin
              if (full) begin
                ovf_nxt = 1'b1;
              end else begin
                total_nxt = total_r + TW'(w_in);
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_QUERY: begin
              if (in_range) begin
                addr_nxt  = day_ext[AW-1:0];
                state_nxt = ST_READ;
              end else begin
                out_nxt.probability = '0;
                out_nxt.hazard      = haz_x[PROB_W-1:0];
                out_nxt.length      = len_x[LEN_W-1:0];
                out_nxt.status      = status_now;
                out_valid_nxt       = 1'b1;
              end
            end
            default: begin
              // The unused code is dropped without a result.
            end
          endcase
        end
      end
      ST_READ: begin
        step_nxt  = '0;
        state_nxt = ST_DIVP;
      end
      ST_DIVP: begin
        rem_nxt  = rem_step;
        quot_nxt = quot_step;
        step_nxt = step_r + STW'(1);
        if (last_step) begin
          prob_nxt  = (total_r == '0) ? '0 : quot_step;
          step_nxt  = '0;
          state_nxt = ST_DIVH;
        end
      end
      ST_DIVH: begin
        rem_nxt  = rem_step;
        quot_nxt = quot_step;
        step_nxt = step_r + STW'(1);
        if (last_step) begin
          out_nxt.probability = prob_x[PROB_W-1:0];
          out_nxt.hazard      = haz_x[PROB_W-1:0];
          out_nxt.length      = len_x[LEN_W-1:0];
          out_nxt.status      = status_now;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    step_r <= step_nxt;
    prob_r <= prob_nxt;
    out_r  <= out_nxt;
  end

  // Weight and prefix store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= {w_in, total_r};
    end
    rd_data_r <= mem[addr_r];
  end

  // A result strobe follows either a last hazard step or a query that
  // needed no division.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r == ST_DIVH) ||
                     $past(in_xfer && (in_data.command == CMD_QUERY))))
    else $error("result strobe without a query behind it");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_DAYS))
    else $error("day count beyond the store depth");

  a_frozen_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> ($stable(count_r) && $stable(total_r) && $stable(ovf_r)))
    else $error("distribution changed during a query");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIVP || state_r == ST_DIVH) && (step_r != '0) && (den != '0))
      |-> (rem_r < den))
    else $error("divider remainder not below the divisor");

  a_overflow_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> full)
    else $error("overflow raised with room left in the store");

endmodule

`default_nettype wire
